// File: hdl/vad_pkg.sv
package vad_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int CORDIC_STAGES_DEF   = 16;

	// Number of tabulated micro-rotation angles; more stages than this run only these.
	localparam int ANG_TABLE_LEN = 24;

	// Angles are in units of 2^-28 rad.
	localparam int ANGLE_WIDTH = 32;
	localparam int DIFF_WIDTH  = 34;
	localparam int OUT_WIDTH   = 16;

	// The datapath holds a component scaled by 2^16 plus three bits of growth headroom.
	localparam int SCALE_SHIFT = 16;
	localparam int HEADROOM    = 3;

	localparam logic signed [ANGLE_WIDTH-1:0] ANG_HALF_PI = 32'sd421657428;
	localparam logic signed [DIFF_WIDTH-1:0]  ANG_PI      = 34'sd843314857;
	localparam logic signed [DIFF_WIDTH-1:0]  ANG_TWO_PI  = 34'sd1686629714;
	localparam logic signed [DIFF_WIDTH-1:0]  ROUND_HALF  = 34'sd16384;
	localparam int ROUND_SHIFT = 15;
	localparam logic signed [DIFF_WIDTH-1:0]  OUT_PI      = 34'sd25736;

	// Effective number of micro-rotation stages.
	function automatic int eff_stages(input int stages);
		return (stages < ANG_TABLE_LEN) ? stages : ANG_TABLE_LEN;
	endfunction

	// Delay from an accepted item to its result strobe, covering pre-rotation,
	// the micro-rotations, then difference, wrap and rounding.
	function automatic int pipe_latency(input int stages);
		return eff_stages(stages) + 4;
	endfunction

	// atan(2^-i) in units of 2^-28 rad, rounded to nearest.
	function automatic logic signed [ANGLE_WIDTH-1:0] atan_ang(input int idx);
		logic signed [ANGLE_WIDTH-1:0] v;
		case (idx)
			0: v = 32'sd210828714;
			1: v = 32'sd124459457;
			2: v = 32'sd65760959;
			3: v = 32'sd33381290;
			4: v = 32'sd16755422;
			5: v = 32'sd8385879;
			6: v = 32'sd4193963;
			7: v = 32'sd2097109;
			8: v = 32'sd1048571;
			9: v = 32'sd524287;
			10: v = 32'sd262144;
			11: v = 32'sd131072;
			12: v = 32'sd65536;
			13: v = 32'sd32768;
			14: v = 32'sd16384;
			15: v = 32'sd8192;
			16: v = 32'sd4096;
			17: v = 32'sd2048;
			18: v = 32'sd1024;
			19: v = 32'sd512;
			20: v = 32'sd256;
			21: v = 32'sd128;
			22: v = 32'sd64;
			23: v = 32'sd32;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/vector_angle_difference.sv
// Channel  | Ports                                      | Handshake
// ---------+--------------------------------------------+---------------------------
// input    | first_x, first_y, second_x, second_y       | start high, busy low
// result   | angle_diff                                 | done high for one cycle
//
// One item is taken in every clock cycle; busy never rises.
// Each result passes through pre-rotation, one register stage per CORDIC
// stage (at most 24 micro-rotations are run), then difference, wrap and
// rounding stages.
// Reset clears only the valid bits; the data registers hold whatever they hold.
// The receiver cannot stall, so results leave the pipeline as they arrive.
module vector_angle_difference #(
	parameter int COMPONENT_WIDTH = vad_pkg::COMPONENT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = vad_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [COMPONENT_WIDTH-1:0]      first_x,
	input  logic signed [COMPONENT_WIDTH-1:0]      first_y,
	input  logic signed [COMPONENT_WIDTH-1:0]      second_x,
	input  logic signed [COMPONENT_WIDTH-1:0]      second_y,
	output logic                                   done,
	output logic signed [vad_pkg::OUT_WIDTH-1:0]   angle_diff
);

	// Register depth of each CORDIC pipeline: pre-rotation plus one stage per micro-rotation.
	localparam int CL = vad_pkg::eff_stages(CORDIC_STAGES) + 1;
	localparam int AW = vad_pkg::ANGLE_WIDTH;
	localparam int DW = vad_pkg::DIFF_WIDTH;

	logic signed [AW-1:0] z_first;
	logic signed [AW-1:0] z_second;

	// Valid and zero-vector flags travel beside the CORDIC data.
	logic                 valid_s [0:CL-1];
	logic                 zero_s  [0:CL-1];
	logic                 in_zero;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 zero_s1, zero_s2;
	logic signed [DW-1:0] diff_s1;
	logic signed [DW-1:0] wrap_s2;
	logic signed [vad_pkg::OUT_WIDTH-1:0] angle_s3;

	logic signed [DW-1:0] rounded;

	// The pipeline never holds items back.
	assign busy = 1'b0;

	// The angle of a zero vector is undefined; such items give zero.
	assign in_zero = ((first_x == '0) && (first_y == '0)) ||
		((second_x == '0) && (second_y == '0));

	vad_cordic #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic_first (
		.clk(clk),
		.x_in(first_x),
		.y_in(first_y),
		.z_out(z_first)
	);

	vad_cordic #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic_second (
		.clk(clk),
		.x_in(second_x),
		.y_in(second_y),
		.z_out(z_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CL; k++) begin
				valid_s[k] <= 1'b0;
			end
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s[0] <= start && !busy;
			for (int k = 1; k < CL; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
			valid_s1 <= valid_s[CL-1];
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Angle difference, then a single wrap into [-pi, pi].
	always_ff @(posedge clk) begin
		zero_s[0] <= in_zero;
		for (int k = 1; k < CL; k++) begin
			zero_s[k] <= zero_s[k-1];
		end

		zero_s1 <= zero_s[CL-1];
		diff_s1 <= DW'(z_second) - DW'(z_first);

		zero_s2 <= zero_s1;
		if (diff_s1 > vad_pkg::ANG_PI) begin
			wrap_s2 <= diff_s1 - vad_pkg::ANG_TWO_PI;
		end else if (diff_s1 < -vad_pkg::ANG_PI) begin
			wrap_s2 <= diff_s1 + vad_pkg::ANG_TWO_PI;
		end else begin
			wrap_s2 <= diff_s1;
		end

		// Round half up to Q3.13 and clamp to plus or minus pi; zero-vector items give zero.
		if (zero_s2) begin
			angle_s3 <= '0;
		end else if (rounded > vad_pkg::OUT_PI) begin
			angle_s3 <= vad_pkg::OUT_WIDTH'(vad_pkg::OUT_PI);
		end else if (rounded < -vad_pkg::OUT_PI) begin
			angle_s3 <= vad_pkg::OUT_WIDTH'(-vad_pkg::OUT_PI);
		end else begin
			angle_s3 <= rounded[vad_pkg::OUT_WIDTH-1:0];
		end
	end

	assign rounded = (wrap_s2 + vad_pkg::ROUND_HALF) >>> vad_pkg::ROUND_SHIFT;

	assign done       = valid_s3;
	assign angle_diff = angle_s3;

endmodule

// File: hdl/vad_cordic.sv
// Pipelined CORDIC vectoring: one register stage for the quarter-turn
// pre-rotation, then one register stage per micro-rotation.
module vad_cordic #(
	parameter int COMPONENT_WIDTH = vad_pkg::COMPONENT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = vad_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                     clk,
	input  logic signed [COMPONENT_WIDTH-1:0]        x_in,
	input  logic signed [COMPONENT_WIDTH-1:0]        y_in,
	output logic signed [vad_pkg::ANGLE_WIDTH-1:0]   z_out
);

	localparam int N  = vad_pkg::eff_stages(CORDIC_STAGES);
	localparam int W  = COMPONENT_WIDTH + vad_pkg::SCALE_SHIFT + vad_pkg::HEADROOM;
	localparam int AW = vad_pkg::ANGLE_WIDTH;

	logic signed [W-1:0]  x_ext;
	logic signed [W-1:0]  y_ext;
	logic signed [W-1:0]  x_s [0:N];
	logic signed [W-1:0]  y_s [0:N];
	logic signed [AW-1:0] z_s [0:N];

	assign x_ext = {{vad_pkg::HEADROOM{x_in[COMPONENT_WIDTH-1]}}, x_in,
		{vad_pkg::SCALE_SHIFT{1'b0}}};
	assign y_ext = {{vad_pkg::HEADROOM{y_in[COMPONENT_WIDTH-1]}}, y_in,
		{vad_pkg::SCALE_SHIFT{1'b0}}};

	// A vector in the left half-plane is turned by a quarter turn so the
	// micro-rotations start from the right half-plane.
	always_ff @(posedge clk) begin
		if (!x_ext[W-1]) begin
			x_s[0] <= x_ext;
			y_s[0] <= y_ext;
			z_s[0] <= '0;
		end else if (!y_ext[W-1]) begin
			x_s[0] <= y_ext;
			y_s[0] <= -x_ext;
			z_s[0] <= vad_pkg::ANG_HALF_PI;
		end else begin
			x_s[0] <= -y_ext;
			y_s[0] <= x_ext;
			z_s[0] <= -vad_pkg::ANG_HALF_PI;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;

		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (!y_s[i][W-1]) begin
				x_s[i+1] <= x_s[i] + dy;
				y_s[i+1] <= y_s[i] - dx;
				z_s[i+1] <= z_s[i] + vad_pkg::atan_ang(i);
			end else begin
				x_s[i+1] <= x_s[i] - dy;
				y_s[i+1] <= y_s[i] + dx;
				z_s[i+1] <= z_s[i] - vad_pkg::atan_ang(i);
			end
		end
	end

	assign z_out = z_s[N];

endmodule

// File: hdl/vad_checker.sv
module vad_checker #(
	parameter int COMPONENT_WIDTH = vad_pkg::COMPONENT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = vad_pkg::CORDIC_STAGES_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic signed [COMPONENT_WIDTH-1:0]     first_x,
	input logic signed [COMPONENT_WIDTH-1:0]     first_y,
	input logic signed [COMPONENT_WIDTH-1:0]     second_x,
	input logic signed [COMPONENT_WIDTH-1:0]     second_y,
	input logic                                  done,
	input logic signed [vad_pkg::OUT_WIDTH-1:0]  angle_diff
);

	localparam int LAT = vad_pkg::pipe_latency(CORDIC_STAGES);

	// Every result strobe traces back to an accepted item a fixed latency earlier.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching start");

	// A result always lies within plus or minus pi.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_diff <= 16'sd25736) && (angle_diff >= -16'sd25736))
		else $error("angle_diff outside plus or minus pi");

	// A zero first vector gives a zero result.
	a_zero_first: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past((first_x == '0) && (first_y == '0), LAT) |-> angle_diff == '0)
		else $error("zero first vector gave a nonzero result");

	// A zero second vector gives a zero result.
	a_zero_second: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past((second_x == '0) && (second_y == '0), LAT) |-> angle_diff == '0)
		else $error("zero second vector gave a nonzero result");

endmodule

bind vector_angle_difference vad_checker #(
	.COMPONENT_WIDTH(COMPONENT_WIDTH),
	.CORDIC_STAGES(CORDIC_STAGES)
) u_vad_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.first_x(first_x),
	.first_y(first_y),
	.second_x(second_x),
	.second_y(second_y),
	.done(done),
	.angle_diff(angle_diff)
);
